FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file of the button event qualifier.
// Depends on nothing; every macro reports through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the active-low reset is low.
`define BEQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication that is only checked while a result transfer is offered.
`define BEQ_ASSERT_OUT(label, clk, rst_n, vld, cond, msg) \
  `BEQ_ASSERT(label, clk, rst_n, (vld) |-> (cond), msg)

`endif

FILE: rtl/beq_pkg.sv
// Types, constants and helper functions of the button event qualifier.
// Depends on nothing; used by the sample and configuration interfaces and all modules.
package beq_pkg;

  localparam int TMR_W     = 16;
  localparam int TS_W      = 32;
  localparam int CFG_IDX_W = 8;

  localparam logic [TMR_W-1:0] DONE_MARK = 16'hFFFF;
  localparam logic [TMR_W-1:0] SAT_MAX   = 16'hFFFE;

  localparam logic [TMR_W-1:0] PRESS_TIME_RST      = 16'd20;
  localparam logic [TMR_W-1:0] RELEASE_TIME_RST    = 16'd20;
  localparam logic [TMR_W-1:0] LONG_PRESS_TIME_RST = 16'd1000;
  localparam logic [TMR_W-1:0] REPEAT_TIME_RST     = 16'd200;

  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_TIME      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_TIME    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_TIME = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_TIME     = 8'd3;

  typedef enum logic [1:0] {
    HELD_RELEASED = 2'd0,
    HELD_PRESSED  = 2'd1,
    HELD_LONG     = 2'd2
  } held_t;

  typedef struct packed {
    logic [TMR_W-1:0] press_time;
    logic [TMR_W-1:0] release_time;
    logic [TMR_W-1:0] long_press_time;
    logic [TMR_W-1:0] repeat_time;
  } cfg_t;

  typedef struct packed {
    logic [TS_W-1:0]  last_stamp;
    logic [TMR_W-1:0] press_timer;
    logic [TMR_W-1:0] release_timer;
    logic [TMR_W-1:0] long_timer;
    logic [TMR_W-1:0] repeat_timer;
    held_t            held_state;
  } state_t;

  typedef struct packed {
    logic [1:0] pressed_state;
    logic       press_event;
    logic       release_event;
    logic       long_press_event;
    logic       long_release_event;
    logic       repeat_event;
  } result_t;

  function automatic logic [TMR_W-1:0] sat_add(input logic [TMR_W-1:0] a,
                                                input logic [TMR_W-1:0] b);
    logic [TMR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, SAT_MAX}) ? SAT_MAX : s[TMR_W-1:0];
  endfunction

endpackage

FILE: rtl/beq_in_if.sv
// Sample channel of the button event qualifier: timestamp and raw level.
// Depends on beq_pkg.
interface beq_in_if;
  logic                         valid;
  logic                         ready;
  logic [beq_pkg::TS_W-1:0]     time_now;
  logic                         raw_level;

  modport source (output valid, output time_now, output raw_level, input ready);
  modport sink   (input valid, input time_now, input raw_level, output ready);
endinterface

FILE: rtl/beq_out_if.sv
// Result channel of the button event qualifier: pressed state and events.
// Depends on nothing outside this file.
interface beq_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] pressed_state;
  logic       press_event;
  logic       release_event;
  logic       long_press_event;
  logic       long_release_event;
  logic       repeat_event;

  modport source (output valid, output pressed_state, output press_event,
                  output release_event, output long_press_event,
                  output long_release_event, output repeat_event, input ready);
  modport sink   (input valid, input pressed_state, input press_event,
                  input release_event, input long_press_event,
                  input long_release_event, input repeat_event, output ready);
endinterface

FILE: rtl/beq_cfg_if.sv
// Configuration write channel of the button event qualifier.
// Depends on beq_pkg.
interface beq_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [beq_pkg::CFG_IDX_W-1:0]   addr;
  logic [beq_pkg::TMR_W-1:0]       data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

FILE: rtl/button_event_qualifier_core.sv
// Top level of the button event qualifier: configuration registers, timer
// state and the result register. Depends on beq_pkg, the three channel
// interfaces and beq_step.
//
// Every accepted sample (timestamp plus raw level) yields exactly one
// registered result: the pressed state and the press, release, long-press,
// long-release and repeat events. The block takes one sample per clock; a
// sample is accepted whenever the result register is empty or its result is
// transferred in the same cycle, so a stalled output only holds the input
// while that one result waits. The rate is set by the combinational timer
// update, where the 16-bit elapsed time is added to the saturating timers and
// compared with the thresholds. Configuration writes are taken every cycle
// and should only be issued while no result is outstanding.
module button_event_qualifier_core (
  input  logic          clk,
  input  logic          rst_n,
  beq_in_if.sink        in_if,
  beq_out_if.source     out_if,
  beq_cfg_if.sink       cfg_if
);

  beq_pkg::cfg_t    cfg_r;
  beq_pkg::state_t  state_r;
  beq_pkg::state_t  state_nxt;
  beq_pkg::result_t res_nxt;
  beq_pkg::result_t out_r;
  logic             out_valid_r;
  logic             in_xfer;

  assign in_if.ready  = !out_valid_r || out_if.ready;
  assign in_xfer      = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  beq_step u_step (
    .cfg       (cfg_r),
    .cur       (state_r),
    .time_now  (in_if.time_now),
    .raw_level (in_if.raw_level),
    .nxt       (state_nxt),
    .res       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.press_time      <= beq_pkg::PRESS_TIME_RST;
      cfg_r.release_time    <= beq_pkg::RELEASE_TIME_RST;
      cfg_r.long_press_time <= beq_pkg::LONG_PRESS_TIME_RST;
      cfg_r.repeat_time     <= beq_pkg::REPEAT_TIME_RST;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.addr)
        beq_pkg::CFG_PRESS_TIME:      cfg_r.press_time      <= cfg_if.data;
        beq_pkg::CFG_RELEASE_TIME:    cfg_r.release_time    <= cfg_if.data;
        beq_pkg::CFG_LONG_PRESS_TIME: cfg_r.long_press_time <= cfg_if.data;
        beq_pkg::CFG_REPEAT_TIME:     cfg_r.repeat_time     <= cfg_if.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.last_stamp    <= '0;
      state_r.press_timer   <= '0;
      state_r.release_timer <= beq_pkg::DONE_MARK;
      state_r.long_timer    <= '0;
      state_r.repeat_timer  <= '0;
      state_r.held_state    <= beq_pkg::HELD_RELEASED;
    end else if (in_xfer) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_r <= res_nxt;
    end
  end

  assign out_if.valid              = out_valid_r;
  assign out_if.pressed_state      = out_r.pressed_state;
  assign out_if.press_event        = out_r.press_event;
  assign out_if.release_event      = out_r.release_event;
  assign out_if.long_press_event   = out_r.long_press_event;
  assign out_if.long_release_event = out_r.long_release_event;
  assign out_if.repeat_event       = out_r.repeat_event;

endmodule

FILE: rtl/beq_step.sv
// Next-state and event logic for one button sample.
// Depends on beq_pkg; instantiated by button_event_qualifier_core.
module beq_step (
  input  beq_pkg::cfg_t                cfg,
  input  beq_pkg::state_t              cur,
  input  logic [beq_pkg::TS_W-1:0]     time_now,
  input  logic                         raw_level,
  output beq_pkg::state_t              nxt,
  output beq_pkg::result_t             res
);

  logic [beq_pkg::TMR_W-1:0] elapsed;
  logic [beq_pkg::TS_W-1:0]  stamp_diff;
  logic [beq_pkg::TMR_W-1:0] press_sum;
  logic [beq_pkg::TMR_W-1:0] release_sum;
  logic [beq_pkg::TMR_W-1:0] long_sum;
  logic [beq_pkg::TMR_W-1:0] repeat_sum;

  assign stamp_diff  = time_now - cur.last_stamp;
  assign elapsed     = stamp_diff[beq_pkg::TMR_W-1:0];
  assign press_sum   = beq_pkg::sat_add(cur.press_timer, elapsed);
  assign release_sum = beq_pkg::sat_add(cur.release_timer, elapsed);
  assign long_sum    = beq_pkg::sat_add(cur.long_timer, elapsed);
  assign repeat_sum  = beq_pkg::sat_add(cur.repeat_timer, elapsed);

  always_comb begin
    nxt                    = cur;
    nxt.last_stamp         = time_now;
    res.press_event        = 1'b0;
    res.release_event      = 1'b0;
    res.long_press_event   = 1'b0;
    res.long_release_event = 1'b0;
    res.repeat_event       = 1'b0;

    if (raw_level) begin
      if (cur.press_timer == beq_pkg::DONE_MARK) begin
        if (repeat_sum >= cfg.repeat_time) begin
          res.repeat_event = 1'b1;
          nxt.repeat_timer = '0;
        end else begin
          nxt.repeat_timer = repeat_sum;
        end
        if (cur.long_timer != beq_pkg::DONE_MARK) begin
          if (cur.long_timer < cfg.long_press_time) begin
            nxt.long_timer = long_sum;
          end else begin
            nxt.long_timer       = beq_pkg::DONE_MARK;
            res.long_press_event = 1'b1;
          end
        end
        nxt.held_state = (nxt.long_timer == beq_pkg::DONE_MARK) ?
                         beq_pkg::HELD_LONG : beq_pkg::HELD_PRESSED;
      end else begin
        if (press_sum >= cfg.press_time) begin
          res.press_event   = 1'b1;
          nxt.press_timer   = beq_pkg::DONE_MARK;
          nxt.release_timer = '0;
          nxt.long_timer    = '0;
          nxt.repeat_timer  = '0;
          nxt.held_state    = beq_pkg::HELD_PRESSED;
        end else begin
          nxt.press_timer = press_sum;
        end
      end
    end else if (cur.release_timer != beq_pkg::DONE_MARK) begin
      if (release_sum >= cfg.release_time) begin
        if (cur.long_timer == beq_pkg::DONE_MARK) begin
          res.long_release_event = 1'b1;
        end else begin
          res.release_event = 1'b1;
        end
        nxt.release_timer = beq_pkg::DONE_MARK;
        nxt.press_timer   = '0;
        nxt.long_timer    = '0;
        nxt.repeat_timer  = '0;
        nxt.held_state    = beq_pkg::HELD_RELEASED;
      end else begin
        nxt.release_timer = release_sum;
      end
    end

    res.pressed_state = nxt.held_state;
  end

endmodule

FILE: rtl/beq_checker.sv
// Port-level checks of the button event qualifier result channel, bound to
// button_event_qualifier_core. Depends on assert_macros.svh and beq_pkg.
`include "assert_macros.svh"

module beq_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] pressed_state,
  input logic       press_event,
  input logic       release_event,
  input logic       long_press_event,
  input logic       long_release_event
);

  `BEQ_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable({pressed_state, press_event, release_event, long_press_event, long_release_event})), "result changed while stalled")
  `BEQ_ASSERT_OUT(a_press_state, clk, rst_n, out_valid && press_event, pressed_state == beq_pkg::HELD_PRESSED, "press event without pressed state")
  `BEQ_ASSERT_OUT(a_release_state, clk, rst_n, out_valid && (release_event || long_release_event), pressed_state == beq_pkg::HELD_RELEASED && !(release_event && long_release_event), "release event inconsistent with state")
  `BEQ_ASSERT_OUT(a_long_state, clk, rst_n, out_valid && long_press_event, pressed_state == beq_pkg::HELD_LONG && !press_event, "long press event without long state")

endmodule

bind button_event_qualifier_core beq_checker u_beq_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_if.valid),
  .out_ready          (out_if.ready),
  .pressed_state      (out_if.pressed_state),
  .press_event        (out_if.press_event),
  .release_event      (out_if.release_event),
  .long_press_event   (out_if.long_press_event),
  .long_release_event (out_if.long_release_event)
);
